[src/dtbi_pkg.sv]
`default_nettype none
package dtbi_pkg;

	localparam int CfgW = 23;
	localparam int CfgIdxW = 3;

	typedef enum logic [2:0] {
		CFG_DPR = 3'd0,
		CFG_LOW = 3'd1,
		CFG_HIGH_A = 3'd2,
		CFG_HIGH_S = 3'd3,
		CFG_TOP_A = 3'd4,
		CFG_TOP_S = 3'd5
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_CLAMP = 2'd1,
		ST_LOAD = 2'd2
	} status_t;

	localparam logic [3:0] FirstSideTable = 4'd9;

	// sequencer states
	typedef enum logic [4:0] {
		S_IDLE,
		S_DEG,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_RD_X1,
		S_RD_X2,
		S_MSRCH_RD,
		S_MSRCH_CMP,
		S_RD_MX1,
		S_RD_MX2,
		S_RD_Y1,
		S_RD_Y2,
		S_LIN_GO,
		S_LIN_WAIT,
		S_OUT
	} state_t;

	// which interpolation of a query is running
	typedef enum logic [1:0] {
		LS_M1,
		LS_M2,
		LS_FIN
	} lin_stage_t;

	// shared interpolation unit request
	typedef struct packed {
		logic start;
		logic signed [32:0] x1;
		logic signed [32:0] x2;
		logic signed [32:0] y1;
		logic signed [32:0] y2;
		logic signed [32:0] x;
	} lin_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic signed [31:0] result;
	} lin_rsp_t;

endpackage
`default_nettype wire

[src/dtbi_lin.sv]
`default_nettype none
// One linear interpolation: multiply, then restoring divide one bit per cycle.
module dtbi_lin
	import dtbi_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire lin_req_t req,
	output lin_rsp_t      rsp
);

	localparam int QW = 66;

	typedef enum logic [1:0] {L_IDLE, L_MUL, L_DIV, L_FIN} lst_t;

	lst_t              st_q;
	logic [32:0]       ady_q, adx_q, span_q;
	logic              neg_q;
	logic              zero_q;
	logic signed [32:0] y1_q;
	logic [QW-1:0]     num_q;
	logic [33:0]       rem_q;
	logic [6:0]        cnt_q;
	logic signed [31:0] res_d;

	logic signed [33:0] dy, dx, sp;
	logic [33:0]       trial;
	logic signed [35:0] sum;
	logic              big;

	function automatic logic [32:0] mag34(input logic signed [33:0] v);
		logic [33:0] m;
		m = v[33] ? -v : v;
		return m[32:0];
	endfunction

	assign dy = 34'(req.y2) - 34'(req.y1);
	assign dx = 34'(req.x) - 34'(req.x1);
	assign sp = 34'(req.x2) - 34'(req.x1);
	assign trial = {rem_q[32:0], num_q[QW-1]} - {1'b0, span_q};
	assign big = (num_q > 66'h200000000);
	assign sum = neg_q ? 36'(y1_q) - 36'(signed'({1'b0, num_q[34:0]}))
		: 36'(y1_q) + 36'(signed'({1'b0, num_q[34:0]}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= L_IDLE;
			cnt_q <= '0;
		end else begin
			case (st_q)
				L_IDLE: if (req.start) st_q <= L_MUL;
				L_MUL: begin
					st_q <= L_DIV;
					cnt_q <= 7'(QW);
				end
				L_DIV: begin
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) st_q <= L_FIN;
				end
				L_FIN: st_q <= L_IDLE;
				default: st_q <= L_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (st_q)
			L_IDLE: begin
				ady_q <= mag34(dy);
				adx_q <= mag34(dx);
				span_q <= mag34(sp);
				zero_q <= (sp == '0);
				neg_q <= (dy[33] != dx[33]) != sp[33];
				y1_q <= req.y1;
			end
			L_MUL: begin
				num_q <= QW'(ady_q) * QW'(adx_q);
				rem_q <= '0;
			end
			L_DIV: begin
				if (!trial[33]) begin
					rem_q <= trial;
					num_q <= {num_q[QW-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[32:0], num_q[QW-1]};
					num_q <= {num_q[QW-2:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	// final sum with saturation, valid while done is high
	always_comb begin
		if (zero_q) res_d = '0;
		else if (big || sum > 36'sd2147483647)
			res_d = (big && neg_q) ? 32'sh80000000 : 32'sh7fffffff;
		else if (sum < -36'sd2147483648) res_d = 32'sh80000000;
		else res_d = sum[31:0];
	end

	assign rsp.busy = (st_q != L_IDLE);
	assign rsp.done = (st_q == L_FIN);
	assign rsp.result = res_d;

	ast_done_clear: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |=> !rsp.busy) else $error("lin done not followed by idle");
	ast_start: assert property (@(posedge clk) disable iff (!arst_n)
		(req.start && !rsp.busy) |=> rsp.busy) else $error("lin did not start");
	ast_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == L_DIV) |-> (cnt_q != 7'd0)) else $error("div count underflow");

endmodule
`default_nettype wire

[src/damping_table_bilinear_interp_unit.sv]
`default_nettype none
// Channel  | dir | handshake              | contents
// s_axis   | in  | s_axis_tvalid/tready   | load word or query
// m_axis   | out | m_axis_tvalid/tready   | coefficient, status
// cfg      | in  | cfg_we                 | register write by index
//
// A load, or a query of a missing table, goes straight to the output register. A
// one-row query reads k (1 to ANGLE_POINTS-1) angle breakpoints and runs one
// interpolation; a bilinear query also reads m (1 to MACH_ROWS-1) Mach breakpoints
// and runs three, each holding the shared unit (multiply, 66-step shift divide).
// Tables live in one single-port memory read once per cycle.
// Reset clears the sequencer and output valid and loads the configuration defaults; table contents stay undefined.
// A result waits in the output register; the sequencer stalls only if it is still full.
module damping_table_bilinear_interp_unit
	import dtbi_pkg::*;
#(
	parameter int TABLE_COUNT = 12,
	parameter int MACH_ROWS = 4,
	parameter int ANGLE_POINTS = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_axis_tvalid,
	output logic               s_axis_tready,
	// mode, table_select, row_index, column_index, table_word, mach, angle
	input  wire logic [103:0]  s_axis_tdata,
	output logic               m_axis_tvalid,
	input  wire logic          m_axis_tready,
	// coefficient, status
	output logic [39:0]        m_axis_tdata,
	input  wire logic          cfg_we,
	input  wire logic [CfgIdxW-1:0] cfg_index,
	input  wire logic [CfgW-1:0]    cfg_data
);

	localparam int RowsN = MACH_ROWS + 1;
	localparam int ColsN = ANGLE_POINTS + 1;
	localparam int TW = $clog2(TABLE_COUNT + 1);
	localparam int RW = $clog2(RowsN + 1);
	localparam int CW = $clog2(ColsN + 1);
	localparam int Depth = TABLE_COUNT * RowsN * ColsN;
	localparam int AW = $clog2(Depth);

	// input fields
	logic               in_mode;
	logic [3:0]         in_tab;
	logic [2:0]         in_row;
	logic [4:0]         in_col;
	logic signed [31:0] in_word;
	logic [19:0]        in_mach;
	logic signed [31:0] in_angle;
	assign in_mode = s_axis_tdata[0];
	assign in_tab = s_axis_tdata[4:1];
	assign in_row = s_axis_tdata[7:5];
	assign in_col = s_axis_tdata[12:8];
	assign in_word = s_axis_tdata[44:13];
	assign in_mach = s_axis_tdata[64:45];
	assign in_angle = s_axis_tdata[96:65];

	// configuration
	logic [22:0] dpr_q;
	logic [19:0] low_q, high_a_q, high_s_q;
	logic [2:0]  top_a_q, top_s_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dpr_q <= 23'd3754936;
			low_q <= 20'd39322;
			high_a_q <= 20'd131072;
			high_s_q <= 20'd78643;
			top_a_q <= 3'd4;
			top_s_q <= 3'd3;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_DPR: dpr_q <= cfg_data;
				CFG_LOW: low_q <= cfg_data[19:0];
				CFG_HIGH_A: high_a_q <= cfg_data[19:0];
				CFG_HIGH_S: high_s_q <= cfg_data[19:0];
				CFG_TOP_A: top_a_q <= cfg_data[2:0];
				CFG_TOP_S: top_s_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// item registers
	state_t             st_q, st_d;
	lin_stage_t         stage_q;
	logic               mode_q;
	logic               bil_q;
	logic [3:0]         tab_q;
	logic [2:0]         row_q;
	logic [4:0]         col_q;
	logic signed [31:0] word_q;
	logic [19:0]        mach_q;
	logic [31:0]        aang_q;
	logic signed [32:0] deg_q;
	logic [CW-1:0]      j_q;
	logic [RW-1:0]      i_q;
	logic [RW-1:0]      ry_q;
	logic signed [31:0] x1_q, x2_q, y1_q, mx1_q, mx2_q, m1_q, m2_q;
	status_t            st_res_q;
	logic signed [31:0] res_q;
	logic               m_valid_q;
	logic [39:0]        m_data_q;

	// table memory
	logic [31:0]        mem [Depth];
	logic               mem_we;
	logic [AW-1:0]      mem_addr;
	logic signed [31:0] rd_q;

	function automatic logic [AW-1:0] addr_of(input logic [TW-1:0] t,
		input logic [RW-1:0] r, input logic [CW-1:0] c);
		return AW'((32'(t) * 32'(RowsN) + 32'(r)) * 32'(ColsN) + 32'(c));
	endfunction

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= word_q;
		rd_q <= mem[mem_addr];
	end

	lin_req_t lreq;
	lin_rsp_t lrsp;

	logic        side;
	logic [2:0]  top_raw;
	logic [RW-1:0] top, bound;
	logic [19:0] high;
	logic        qmode_low, qmode_high;
	logic [54:0] prod;
	logic        tab_ok, load_ok;
	logic signed [32:0] mach_s;
	logic        deg_gt, mach_gt, out_free;
	logic [RW-1:0] yrow1, yrow2;
	logic [CW-1:0] ycol1, ycol2;

	assign side = (tab_q >= FirstSideTable);
	assign top_raw = side ? top_s_q : top_a_q;
	assign top = (top_raw < 3'd1) ? RW'(1)
		: (32'(top_raw) > MACH_ROWS) ? RW'(MACH_ROWS) : RW'(top_raw);
	assign bound = (top < RW'(2)) ? RW'(2) : top;
	assign high = side ? high_s_q : high_a_q;
	assign qmode_low = (mach_q < low_q);
	assign qmode_high = !qmode_low && (mach_q > high);
	assign prod = 55'(aang_q) * 55'(dpr_q);
	assign tab_ok = (32'(tab_q) < TABLE_COUNT);
	assign load_ok = tab_ok && (32'(row_q) <= MACH_ROWS) && (32'(col_q) <= ANGLE_POINTS);
	assign mach_s = signed'({13'd0, mach_q});
	assign deg_gt = (deg_q > 33'(rd_q));
	assign mach_gt = (mach_s > 33'(rd_q));
	assign out_free = !m_valid_q || m_axis_tready;

	// cells of the two y values for the current interpolation
	assign yrow1 = bil_q ? i_q - RW'(1) : ry_q;
	assign yrow2 = bil_q ? i_q : ry_q;
	assign ycol1 = (bil_q && stage_q == LS_M2) ? j_q + CW'(1) : j_q;
	assign ycol2 = bil_q ? ycol1 : j_q + CW'(1);

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			S_IDLE: if (s_axis_tvalid && s_axis_tready) st_d = S_DEG;
			S_DEG: st_d = (mode_q && tab_ok) ? S_SRCH_RD : S_OUT;
			S_SRCH_RD: st_d = S_SRCH_CMP;
			S_SRCH_CMP:
				if (deg_gt && 32'(j_q) < ANGLE_POINTS - 1) st_d = S_SRCH_RD;
				else st_d = S_RD_X1;
			S_RD_X1: st_d = S_RD_X2;
			S_RD_X2: st_d = (qmode_low || qmode_high) ? S_RD_Y1 : S_MSRCH_RD;
			S_MSRCH_RD: st_d = S_MSRCH_CMP;
			S_MSRCH_CMP:
				if (i_q < bound && mach_gt) st_d = S_MSRCH_RD;
				else st_d = S_RD_MX1;
			S_RD_MX1: st_d = S_RD_MX2;
			S_RD_MX2: st_d = S_RD_Y1;
			S_RD_Y1: st_d = S_RD_Y2;
			S_RD_Y2: st_d = S_LIN_GO;
			S_LIN_GO: st_d = S_LIN_WAIT;
			S_LIN_WAIT:
				if (lrsp.done) begin
					case (stage_q)
						LS_M1: st_d = S_RD_Y1;
						LS_M2: st_d = S_LIN_GO;
						default: st_d = S_OUT;
					endcase
				end
			S_OUT: if (out_free) st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end

	// memory address and interpolation request per state
	always_comb begin
		mem_we = 1'b0;
		mem_addr = '0;
		lreq = '0;
		case (st_q)
			S_DEG: begin
				mem_we = !mode_q && load_ok;
				mem_addr = addr_of(TW'(tab_q), RW'(row_q), CW'(col_q));
			end
			S_SRCH_RD: mem_addr = addr_of(TW'(tab_q), '0, j_q + CW'(1));
			S_RD_X1: mem_addr = addr_of(TW'(tab_q), '0, j_q);
			S_MSRCH_RD: mem_addr = addr_of(TW'(tab_q), i_q, '0);
			S_RD_MX1: mem_addr = addr_of(TW'(tab_q), i_q - RW'(1), '0);
			S_RD_Y1: mem_addr = addr_of(TW'(tab_q), yrow1, ycol1);
			S_RD_Y2: mem_addr = addr_of(TW'(tab_q), yrow2, ycol2);
			S_LIN_GO: begin
				lreq.start = 1'b1;
				if (stage_q == LS_FIN) begin
					lreq.x1 = 33'(x1_q);
					lreq.x2 = 33'(x2_q);
					lreq.y1 = bil_q ? 33'(m1_q) : 33'(y1_q);
					lreq.y2 = bil_q ? 33'(m2_q) : 33'(rd_q);
					lreq.x = deg_q;
				end else begin
					lreq.x1 = 33'(mx1_q);
					lreq.x2 = 33'(mx2_q);
					lreq.y1 = 33'(y1_q);
					lreq.y2 = 33'(rd_q);
					lreq.x = mach_s;
				end
			end
			default: ;
		endcase
	end

	dtbi_lin u_lin (.clk(clk), .arst_n(arst_n), .req(lreq), .rsp(lrsp));

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= S_IDLE;
		else st_q <= st_d;
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				mode_q <= in_mode;
				tab_q <= in_tab;
				row_q <= in_row;
				col_q <= in_col;
				word_q <= in_word;
				mach_q <= in_mach;
				aang_q <= in_angle[31] ? 32'(-in_angle) : in_angle;
				j_q <= CW'(1);
				i_q <= RW'(2);
				st_res_q <= ST_OK;
				res_q <= '0;
			end
			S_DEG: begin
				deg_q <= (prod[54:16] > 39'd2147483647) ? 33'sd2147483647
					: signed'({1'b0, prod[47:16]});
				if (!mode_q) st_res_q <= ST_LOAD;
			end
			// rd_q holds row0[j+1]; the last one read is the segment's upper breakpoint
			S_SRCH_CMP: begin
				x2_q <= rd_q;
				if (deg_gt && 32'(j_q) < ANGLE_POINTS - 1) j_q <= j_q + CW'(1);
				else if (deg_gt) st_res_q <= ST_CLAMP;
			end
			S_RD_X2: begin
				x1_q <= rd_q;
				bil_q <= !(qmode_low || qmode_high);
				stage_q <= (qmode_low || qmode_high) ? LS_FIN : LS_M1;
				ry_q <= qmode_low ? RW'(1) : top;
			end
			S_MSRCH_CMP: begin
				mx2_q <= rd_q;
				if (i_q < bound && mach_gt) i_q <= i_q + RW'(1);
			end
			S_RD_MX2: mx1_q <= rd_q;
			S_RD_Y2: y1_q <= rd_q;
			S_LIN_WAIT:
				if (lrsp.done) begin
					case (stage_q)
						LS_M1: begin
							m1_q <= lrsp.result;
							stage_q <= LS_M2;
						end
						LS_M2: begin
							m2_q <= lrsp.result;
							stage_q <= LS_FIN;
						end
						default: res_q <= lrsp.result;
					endcase
				end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_valid_q <= 1'b0;
		else if (st_q == S_OUT && out_free) m_valid_q <= 1'b1;
		else if (m_axis_tready) m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (st_q == S_OUT && out_free) m_data_q <= {6'd0, st_res_q, res_q};
	end

	assign s_axis_tready = (st_q == S_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = m_data_q;

	ast_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("result dropped");
	ast_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
		else $error("result changed while waiting");
	ast_load_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[33:32] == ST_LOAD) |-> (m_axis_tdata[31:0] == '0))
		else $error("bad load result");
	ast_lin_free: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_LIN_GO) |-> !lrsp.busy) else $error("interpolation unit still busy");

endmodule
`default_nettype wire
